### sv/bcu_pkg.sv
package bcu_pkg;

  // operand and result widths
  localparam int unsigned ARG_W   = 7;
  localparam int unsigned RES_W   = 64;
  localparam int unsigned MAX_N   = 67;

  // wide intermediate: 64-bit value times 7-bit factor, padded to whole digits
  localparam int unsigned DIG_W     = 8;
  localparam int unsigned PROD_W    = 72;
  localparam int unsigned DIV_STEPS = PROD_W / DIG_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

endpackage

### sv/bcu_div.sv
module bcu_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [bcu_pkg::PROD_W-1:0]     dividend,
  input  logic [bcu_pkg::ARG_W-1:0]      divisor,
  output logic                           done,
  output logic [bcu_pkg::PROD_W-1:0]     quotient
);

  logic [bcu_pkg::PROD_W-1:0] quo_r, quo_nxt;
  logic [bcu_pkg::ARG_W-1:0]  rem_r, rem_nxt;
  logic [bcu_pkg::ARG_W-1:0]  div_r;
  logic [bcu_pkg::CNT_W-1:0]  cnt_r;
  logic                       done_r;

  // one radix-256 digit of restoring long division per cycle
  always_comb begin
    logic [bcu_pkg::ARG_W:0] trial;
    logic                    qbit;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int j = 0; j < bcu_pkg::DIG_W; j++) begin
      trial = {rem_nxt, quo_nxt[bcu_pkg::PROD_W-1]};
      qbit  = (trial >= {1'b0, div_r});
      if (qbit) begin
        rem_nxt = bcu_pkg::ARG_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[bcu_pkg::ARG_W-1:0];
      end
      quo_nxt = {quo_nxt[bcu_pkg::PROD_W-2:0], qbit};
    end
  end

  // control: digit counter and completion flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= bcu_pkg::CNT_W'(bcu_pkg::DIV_STEPS);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == bcu_pkg::CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  // datapath: dividend shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### sv/binomial_coefficient_unit.sv
// binomial coefficient C(n,k) by the multiplicative recurrence
// a new item runs min(k,n-k) steps; an invalid request or k of 0 or n skips the steps
// each step is a multiply on the shared 64x7 multiplier, a digit-serial pass through the
// shared divider and an update, so at most 33 steps
// one item at a time: the next item is accepted only once the result is handed over
// reset (rst_n low, synchronous) returns the sequencer to idle and drops out_valid
module binomial_coefficient_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bcu_pkg::ARG_W-1:0]    in_n_value,
  input  logic [bcu_pkg::ARG_W-1:0]    in_k_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bcu_pkg::RES_W-1:0]    out_coefficient,
  output logic                         out_invalid
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                          state_r, state_nxt;
  logic [bcu_pkg::RES_W-1:0]       value_r, value_nxt;
  logic                            inv_r, inv_nxt;
  logic [bcu_pkg::ARG_W-1:0]       n_r, n_nxt;
  logic [bcu_pkg::ARG_W-1:0]       kk_r, kk_nxt;
  logic [bcu_pkg::ARG_W-1:0]       i_r, i_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [bcu_pkg::RES_W-1:0]       out_coef_r, out_coef_nxt;
  logic                            out_inv_r, out_inv_nxt;

  logic                            div_start;
  logic                            div_done;
  logic [bcu_pkg::PROD_W-1:0]      div_quo;
  logic [bcu_pkg::ARG_W-1:0]       mult;
  logic [bcu_pkg::ARG_W-1:0]       dvsr;
  logic [bcu_pkg::PROD_W-2:0]      prod;
  logic [bcu_pkg::ARG_W-1:0]       n_minus_k;
  logic                            bad_req;
  logic [bcu_pkg::ARG_W-1:0]       i_inc;

  // shared multiplier: value times (n - i), divided later by (i + 1)
  assign mult  = n_r - i_r;
  assign i_inc = i_r + 1'b1;
  assign dvsr  = i_inc;
  assign prod  = (bcu_pkg::PROD_W-1)'(value_r) * (bcu_pkg::PROD_W-1)'(mult);

  assign div_start = (state_r == ST_MUL);

  bcu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({1'b0, prod}),
    .divisor  (dvsr),
    .done     (div_done),
    .quotient (div_quo)
  );

  // request checks on the incoming item
  assign n_minus_k = in_n_value - in_k_value;
  assign bad_req   = (in_k_value > in_n_value)
                   || (in_n_value > bcu_pkg::ARG_W'(bcu_pkg::MAX_N));

  assign in_ready = (state_r == ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    value_nxt     = value_r;
    inv_nxt       = inv_r;
    n_nxt         = n_r;
    kk_nxt        = kk_r;
    i_nxt         = i_r;
    out_valid_nxt = out_valid_r;
    out_coef_nxt  = out_coef_r;
    out_inv_nxt   = out_inv_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          n_nxt = in_n_value;
          i_nxt = '0;
          if (bad_req) begin
            value_nxt = '0;
            inv_nxt   = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            value_nxt = bcu_pkg::RES_W'(1);
            inv_nxt   = 1'b0;
            kk_nxt    = (in_k_value > n_minus_k) ? n_minus_k : in_k_value;
            state_nxt = ((in_k_value == '0) || (n_minus_k == '0)) ? ST_DONE : ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          value_nxt = div_quo[bcu_pkg::RES_W-1:0];
          i_nxt     = i_inc;
          state_nxt = (i_inc == kk_r) ? ST_DONE : ST_MUL;
        end
      end
      ST_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_coef_nxt  = value_r;
          out_inv_nxt   = inv_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    value_r    <= value_nxt;
    inv_r      <= inv_nxt;
    n_r        <= n_nxt;
    kk_r       <= kk_nxt;
    i_r        <= i_nxt;
    out_coef_r <= out_coef_nxt;
    out_inv_r  <= out_inv_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_coefficient = out_coef_r;
  assign out_invalid     = out_inv_r;

endmodule
